### src/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, opcodes and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_W      = 16;
   localparam int FRAC_W      = 12;
   localparam int TOL_W       = 15;
   localparam int OPCODE_W    = 4;
   localparam int DIV_QBITS   = 17;
   localparam int SQRT_STEPS  = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int PIPE_STEPS  = 17;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [OPCODE_W-1:0] OP_ADD   = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_SUB   = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_MUL   = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_DIV   = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_CONJ  = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_MAG   = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_PHASE = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_EQUAL = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_LESS  = 4'd8;

   localparam logic [DATA_W-1:0] VMAX = 16'h7FFF;
   localparam logic [DATA_W-1:0] VMIN = 16'h8000;
   localparam logic signed [33:0] HALF_PI = 34'sd1686629713;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [DATA_W-1:0]   a_re;
      logic [DATA_W-1:0]   a_im;
      logic [DATA_W-1:0]   b_re;
      logic [DATA_W-1:0]   b_im;
      logic                eq_hit;
   } item_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'd843314857;
         5'd1:  v = 32'd497837829;
         5'd2:  v = 32'd263043837;
         5'd3:  v = 32'd133525159;
         5'd4:  v = 32'd67021687;
         5'd5:  v = 32'd33543516;
         5'd6:  v = 32'd16775851;
         5'd7:  v = 32'd8388437;
         5'd8:  v = 32'd4194283;
         5'd9:  v = 32'd2097149;
         5'd10: v = 32'd1048576;
         5'd11: v = 32'd524288;
         5'd12: v = 32'd262144;
         5'd13: v = 32'd131072;
         5'd14: v = 32'd65536;
         5'd15: v = 32'd32768;
         5'd16: v = 32'd16384;
         5'd17: v = 32'd8192;
         5'd18: v = 32'd4096;
         5'd19: v = 32'd2048;
         5'd20: v = 32'd1024;
         5'd21: v = 32'd512;
         5'd22: v = 32'd256;
         5'd23: v = 32'd128;
         5'd24: v = 32'd64;
         5'd25: v = 32'd32;
         5'd26: v = 32'd16;
         5'd27: v = 32'd8;
         5'd28: v = 32'd4;
         5'd29: v = 32'd2;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

### src/cau_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_req_if
// Request channel: opcode and two complex operands.
// ----------------------------------------------------------------------------
interface cau_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  opcode;
   logic signed [15:0] a_re;
   logic signed [15:0] a_im;
   logic signed [15:0] b_re;
   logic signed [15:0] b_im;

   modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

### src/cau_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_rsp_if
// Response channel: complex result and status flags.
// ----------------------------------------------------------------------------
interface cau_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] res_re;
   logic signed [15:0] res_im;
   logic        compare_true;
   logic        div_zero;
   logic        saturated;

   modport source (output valid, res_re, res_im, compare_true, div_zero, saturated,
                   input ready);
   modport sink   (input valid, res_re, res_im, compare_true, div_zero, saturated,
                   output ready);
endinterface

### src/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Accepts request transactions and resolves the tolerance equality test.
// ----------------------------------------------------------------------------
module cau_front (
   cau_req_if.sink            req,
   input  logic [14:0]        tolerance,
   output logic               out_valid,
   input  logic               out_ready,
   output cau_pkg::item_type  out_item
);

   logic [16:0] diff_re;
   logic [16:0] diff_im;
   logic [16:0] mag_re;
   logic [16:0] mag_im;
   logic [16:0] tol_eff;

   assign req.ready = out_ready;
   assign out_valid = req.valid;

   always_comb begin
      diff_re = {req.a_re[15], req.a_re} - {req.b_re[15], req.b_re};
      diff_im = {req.a_im[15], req.a_im} - {req.b_im[15], req.b_im};
      mag_re  = diff_re[16] ? 17'(-diff_re) : diff_re;
      mag_im  = diff_im[16] ? 17'(-diff_im) : diff_im;
      tol_eff = (tolerance == '0) ? 17'd1 : {2'b00, tolerance};
      out_item.opcode = req.opcode;
      out_item.a_re   = req.a_re;
      out_item.a_im   = req.a_im;
      out_item.b_re   = req.b_re;
      out_item.b_im   = req.b_im;
      out_item.eq_hit = (mag_re < tol_eff) && (mag_im < tol_eff);
   end

endmodule

### src/cau_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_queue
// Short queue decoupling the front end from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module cau_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  cau_pkg::item_type  wr_item,
   output logic               rd_valid,
   input  logic               rd_ready,
   output cau_pkg::item_type  rd_item
);

   cau_pkg::item_type                mem_ff [cau_pkg::QUEUE_DEPTH];
   logic [cau_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [cau_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [cau_pkg::QPTR_W:0]         count_ff, count_in;
   logic                             push;
   logic                             pop;

   assign wr_ready = (count_ff != 3'(cau_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {2'b00, push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

### src/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back
// Arithmetic pipeline: products, sums, then parallel lanes with one divide
// step per stage, root and cordic steps in all but the last, then selection.
// ----------------------------------------------------------------------------
module cau_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  cau_pkg::item_type  in_item,
   cau_rsp_if.source          rsp
);

   localparam int RW = 50;

   typedef struct packed {
      logic        valid;
      logic [3:0]  op;
      logic [15:0] re;
      logic [15:0] im;
      logic        cmp;
      logic        sat;
      logic [31:0] rr, ii, ri, ir, sar, sai, sbr, sbi;
      logic [19:0] cx;
      logic [19:0] cy;
      logic [33:0] cz;
      logic        pzero;
   } s1_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  op;
      logic [15:0] re;
      logic [15:0] im;
      logic        cmp;
      logic        sat;
      logic [33:0] mre, mim, nre, nim;
      logic [32:0] dd;
      logic [32:0] sa;
      logic [19:0] cx;
      logic [19:0] cy;
      logic [33:0] cz;
      logic        pzero;
   } s2_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  op;
      logic [15:0] re;
      logic [15:0] im;
      logic        cmp;
      logic        sat;
      logic        mneg_re, mneg_im, dneg_re, dneg_im;
      logic [32:0] mm_re, mm_im, dm_re, dm_im;
      logic [32:0] dd;
      logic [32:0] sa;
      logic [19:0] cx;
      logic [19:0] cy;
      logic [33:0] cz;
      logic        pzero;
   } s3_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  op;
      logic [15:0] re;
      logic [15:0] im;
      logic        cmp;
      logic        sat;
      logic [32:0] dd;
      logic [RW-1:0] dr_re, dr_im;
      logic [16:0] dq_re, dq_im;
      logic        dn_re, dn_im, dov_re, dov_im;
      logic [32:0] sv;
      logic [32:0] sres;
      logic [19:0] cx;
      logic [19:0] cy;
      logic [33:0] cz;
      logic        pzero;
   } it_type;

   function automatic logic [16:0] sat17(input logic [16:0] v);
      logic ovf;
      ovf = (v[16] != v[15]);
      return ovf ? {1'b1, (v[16] ? cau_pkg::VMIN : cau_pkg::VMAX)} : {1'b0, v[15:0]};
   endfunction

   function automatic logic [16:0] satsm(input logic neg, input logic [33:0] m);
      logic [33:0] n;
      n = 34'(-m);
      if (!neg) begin
         return (m > 34'd32767) ? {1'b1, cau_pkg::VMAX} : {1'b0, m[15:0]};
      end
      return (m > 34'd32768) ? {1'b1, cau_pkg::VMIN} : {1'b0, n[15:0]};
   endfunction

   logic   en;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   it_type it_ff [cau_pkg::PIPE_STEPS+1];
   it_type it_in [cau_pkg::PIPE_STEPS+1];

   logic        out_valid_ff;
   logic [15:0] out_re_ff, out_re_in;
   logic [15:0] out_im_ff, out_im_in;
   logic        out_cmp_ff, out_cmp_in;
   logic        out_dz_ff, out_dz_in;
   logic        out_sat_ff, out_sat_in;

   assign en       = !out_valid_ff || rsp.ready;
   assign in_ready = en;

   // stage 1: products, simple operations, cordic pre-rotation
   always_comb begin
      logic signed [15:0] ar, ai, br, bi;
      logic [16:0] t_re, t_im;
      ar = in_item.a_re;
      ai = in_item.a_im;
      br = in_item.b_re;
      bi = in_item.b_im;
      s1_in       = '0;
      s1_in.valid = in_valid;
      s1_in.op    = in_item.opcode;
      s1_in.rr    = ar * br;
      s1_in.ii    = ai * bi;
      s1_in.ri    = ar * bi;
      s1_in.ir    = ai * br;
      s1_in.sar   = ar * ar;
      s1_in.sai   = ai * ai;
      s1_in.sbr   = br * br;
      s1_in.sbi   = bi * bi;
      t_re = '0;
      t_im = '0;
      unique case (in_item.opcode)
         cau_pkg::OP_ADD: begin
            t_re = sat17({ar[15], ar} + {br[15], br});
            t_im = sat17({ai[15], ai} + {bi[15], bi});
         end
         cau_pkg::OP_SUB: begin
            t_re = sat17({ar[15], ar} - {br[15], br});
            t_im = sat17({ai[15], ai} - {bi[15], bi});
         end
         cau_pkg::OP_CONJ: begin
            t_re = {1'b0, ar};
            t_im = sat17(17'(-{ai[15], ai}));
         end
         cau_pkg::OP_EQUAL: begin
            s1_in.cmp = in_item.eq_hit;
         end
         default: begin
            t_re = '0;
         end
      endcase
      s1_in.re  = t_re[15:0];
      s1_in.im  = t_im[15:0];
      s1_in.sat = t_re[16] | t_im[16];
      s1_in.pzero = (ar == '0) && (ai == '0);
      if (ar[15]) begin
         if (!ai[15]) begin
            s1_in.cx = 20'(ai);
            s1_in.cy = 20'(-20'(ar));
            s1_in.cz = cau_pkg::HALF_PI;
         end else begin
            s1_in.cx = 20'(-20'(ai));
            s1_in.cy = 20'(ar);
            s1_in.cz = -cau_pkg::HALF_PI;
         end
      end else begin
         s1_in.cx = 20'(ar);
         s1_in.cy = 20'(ai);
         s1_in.cz = '0;
      end
   end

   // stage 2: sums of products
   always_comb begin
      s2_in.valid = s1_ff.valid;
      s2_in.op    = s1_ff.op;
      s2_in.re    = s1_ff.re;
      s2_in.im    = s1_ff.im;
      s2_in.cmp   = s1_ff.cmp;
      s2_in.sat   = s1_ff.sat;
      s2_in.mre   = 34'($signed(s1_ff.rr)) - 34'($signed(s1_ff.ii));
      s2_in.mim   = 34'($signed(s1_ff.ri)) + 34'($signed(s1_ff.ir));
      s2_in.nre   = 34'($signed(s1_ff.rr)) + 34'($signed(s1_ff.ii));
      s2_in.nim   = 34'($signed(s1_ff.ir)) - 34'($signed(s1_ff.ri));
      s2_in.dd    = 33'(s1_ff.sbr) + 33'(s1_ff.sbi);
      s2_in.sa    = 33'(s1_ff.sar) + 33'(s1_ff.sai);
      s2_in.cx    = s1_ff.cx;
      s2_in.cy    = s1_ff.cy;
      s2_in.cz    = s1_ff.cz;
      s2_in.pzero = s1_ff.pzero;
   end

   // stage 3: sign and magnitude, magnitude compare
   always_comb begin
      s3_in.valid   = s2_ff.valid;
      s3_in.op      = s2_ff.op;
      s3_in.re      = s2_ff.re;
      s3_in.im      = s2_ff.im;
      s3_in.cmp     = (s2_ff.op == cau_pkg::OP_LESS) ? (s2_ff.sa < s2_ff.dd) : s2_ff.cmp;
      s3_in.sat     = s2_ff.sat;
      s3_in.mneg_re = s2_ff.mre[33];
      s3_in.mneg_im = s2_ff.mim[33];
      s3_in.dneg_re = s2_ff.nre[33];
      s3_in.dneg_im = s2_ff.nim[33];
      s3_in.mm_re   = s2_ff.mre[33] ? 33'(-s2_ff.mre) : s2_ff.mre[32:0];
      s3_in.mm_im   = s2_ff.mim[33] ? 33'(-s2_ff.mim) : s2_ff.mim[32:0];
      s3_in.dm_re   = s2_ff.nre[33] ? 33'(-s2_ff.nre) : s2_ff.nre[32:0];
      s3_in.dm_im   = s2_ff.nim[33] ? 33'(-s2_ff.nim) : s2_ff.nim[32:0];
      s3_in.dd      = s2_ff.dd;
      s3_in.sa      = s2_ff.sa;
      s3_in.cx      = s2_ff.cx;
      s3_in.cy      = s2_ff.cy;
      s3_in.cz      = s2_ff.cz;
      s3_in.pzero   = s2_ff.pzero;
   end

   // stage 4: multiply rounding, divider and square root set-up
   always_comb begin
      logic [16:0] m_re, m_im;
      m_re = satsm(s3_ff.mneg_re,
                   (34'(s3_ff.mm_re) + 34'(1 << (cau_pkg::FRAC_W - 1))) >> cau_pkg::FRAC_W);
      m_im = satsm(s3_ff.mneg_im,
                   (34'(s3_ff.mm_im) + 34'(1 << (cau_pkg::FRAC_W - 1))) >> cau_pkg::FRAC_W);
      it_in[0].valid = s3_ff.valid;
      it_in[0].op    = s3_ff.op;
      it_in[0].cmp   = s3_ff.cmp;
      if (s3_ff.op == cau_pkg::OP_MUL) begin
         it_in[0].re  = m_re[15:0];
         it_in[0].im  = m_im[15:0];
         it_in[0].sat = m_re[16] | m_im[16];
      end else begin
         it_in[0].re  = s3_ff.re;
         it_in[0].im  = s3_ff.im;
         it_in[0].sat = s3_ff.sat;
      end
      it_in[0].dd     = s3_ff.dd;
      it_in[0].dr_re  = RW'({s3_ff.dm_re, 12'b0});
      it_in[0].dr_im  = RW'({s3_ff.dm_im, 12'b0});
      it_in[0].dq_re  = '0;
      it_in[0].dq_im  = '0;
      it_in[0].dn_re  = s3_ff.dneg_re;
      it_in[0].dn_im  = s3_ff.dneg_im;
      it_in[0].dov_re = 38'(s3_ff.dm_re) >= {s3_ff.dd, 5'b0};
      it_in[0].dov_im = 38'(s3_ff.dm_im) >= {s3_ff.dd, 5'b0};
      it_in[0].sv     = s3_ff.sa;
      it_in[0].sres   = '0;
      it_in[0].cx     = s3_ff.cx;
      it_in[0].cy     = s3_ff.cy;
      it_in[0].cz     = s3_ff.cz;
      it_in[0].pzero  = s3_ff.pzero;
   end

   // one quotient bit per stage; root bit and cordic rotation in all but the last
   for (genvar j = 0; j < cau_pkg::PIPE_STEPS; j++) begin : g_step
      localparam int QB = cau_pkg::PIPE_STEPS - 1 - j;
      localparam int SB = (j < cau_pkg::SQRT_STEPS) ? 30 - 2 * j : 0;
      always_comb begin
         logic [RW-1:0] dk;
         logic [32:0]   trial;
         logic signed [19:0] xs, ys;
         logic signed [33:0] ang;
         it_in[j+1] = it_ff[j];
         dk = RW'(it_ff[j].dd) << QB;
         if (it_ff[j].dr_re >= dk) begin
            it_in[j+1].dr_re     = it_ff[j].dr_re - dk;
            it_in[j+1].dq_re[QB] = 1'b1;
         end
         if (it_ff[j].dr_im >= dk) begin
            it_in[j+1].dr_im     = it_ff[j].dr_im - dk;
            it_in[j+1].dq_im[QB] = 1'b1;
         end
         trial = '0;
         xs    = '0;
         ys    = '0;
         ang   = '0;
         if (j < cau_pkg::SQRT_STEPS) begin
            trial = it_ff[j].sres + (33'd1 << SB);
            if (it_ff[j].sv >= trial) begin
               it_in[j+1].sv   = it_ff[j].sv - trial;
               it_in[j+1].sres = (it_ff[j].sres >> 1) + (33'd1 << SB);
            end else begin
               it_in[j+1].sres = it_ff[j].sres >> 1;
            end
         end
         if (j < cau_pkg::CORDIC_STEPS) begin
            xs  = $signed(it_ff[j].cx) >>> j;
            ys  = $signed(it_ff[j].cy) >>> j;
            ang = 34'(cau_pkg::atan_q30(5'(j)));
            if (!it_ff[j].cy[19]) begin
               it_in[j+1].cx = $signed(it_ff[j].cx) + ys;
               it_in[j+1].cy = $signed(it_ff[j].cy) - xs;
               it_in[j+1].cz = $signed(it_ff[j].cz) + ang;
            end else begin
               it_in[j+1].cx = $signed(it_ff[j].cx) - ys;
               it_in[j+1].cy = $signed(it_ff[j].cy) + xs;
               it_in[j+1].cz = $signed(it_ff[j].cz) - ang;
            end
         end
      end
   end

   // result selection
   always_comb begin
      it_type      fin;
      logic [16:0] q_re, q_im, root;
      logic signed [33:0] zr;
      fin  = it_ff[cau_pkg::PIPE_STEPS];
      q_re = satsm(fin.dn_re, fin.dov_re ? 34'(1 << cau_pkg::DIV_QBITS) : 34'(fin.dq_re));
      q_im = satsm(fin.dn_im, fin.dov_im ? 34'(1 << cau_pkg::DIV_QBITS) : 34'(fin.dq_im));
      root = satsm(1'b0, 34'(fin.sres));
      zr   = ($signed(fin.cz) + 34'sd131072) >>> (30 - cau_pkg::FRAC_W);
      out_re_in  = fin.re;
      out_im_in  = fin.im;
      out_cmp_in = fin.cmp;
      out_sat_in = fin.sat;
      out_dz_in  = 1'b0;
      unique case (fin.op)
         cau_pkg::OP_DIV: begin
            if (fin.dd == '0) begin
               out_re_in  = '0;
               out_im_in  = '0;
               out_sat_in = 1'b0;
               out_dz_in  = 1'b1;
            end else begin
               out_re_in  = q_re[15:0];
               out_im_in  = q_im[15:0];
               out_sat_in = q_re[16] | q_im[16];
            end
         end
         cau_pkg::OP_MAG: begin
            out_re_in  = root[15:0];
            out_im_in  = '0;
            out_sat_in = root[16];
         end
         cau_pkg::OP_PHASE: begin
            out_re_in  = fin.pzero ? '0 : zr[15:0];
            out_im_in  = '0;
            out_sat_in = 1'b0;
         end
         default: begin
            out_dz_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         s3_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         out_valid_ff <= it_ff[cau_pkg::PIPE_STEPS].valid;
      end
   end

   for (genvar k = 0; k <= cau_pkg::PIPE_STEPS; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            it_ff[k].valid <= 1'b0;
         end else if (en) begin
            it_ff[k] <= it_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_re_ff  <= out_re_in;
         out_im_ff  <= out_im_in;
         out_cmp_ff <= out_cmp_in;
         out_dz_ff  <= out_dz_in;
         out_sat_ff <= out_sat_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.res_re       = out_re_ff;
   assign rsp.res_im       = out_im_ff;
   assign rsp.compare_true = out_cmp_ff;
   assign rsp.div_zero     = out_dz_ff;
   assign rsp.saturated    = out_sat_ff;

endmodule

### src/complex_arith_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_core
// Fixed-point complex ALU: add, sub, mul, div, conj, magnitude, phase,
// tolerance equality and magnitude compare.
//
//   port       direction  contents
//   req_chan   in         opcode, a_re, a_im, b_re, b_im (Q4.12)
//   rsp_chan   out        res_re, res_im, compare_true, div_zero, saturated
//   csr_*      in         equal_tolerance write
//
// one transaction per cycle sustained while the response is not stalled; each
// result passes the product, sum and sign stages and the 17-step divider lanes.
// synchronous reset clears the queue, stage valids and the tolerance.
// a stalled response freezes the pipeline; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module complex_arith_unit_core (
   input  logic        clock,
   input  logic        reset,
   cau_req_if.sink     req_chan,
   cau_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [14:0] csr_wdata
);

   logic [cau_pkg::TOL_W-1:0] tol_ff;
   logic [cau_pkg::TOL_W-1:0] tol_in;
   logic                      fr_valid;
   logic                      fr_ready;
   cau_pkg::item_type         fr_item;
   logic                      bk_valid;
   logic                      bk_ready;
   cau_pkg::item_type         bk_item;

   assign tol_in = csr_we ? csr_wdata : tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else begin
         tol_ff <= tol_in;
      end
   end

   cau_front u_front (
      .req       (req_chan),
      .tolerance (tol_ff),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_item  (fr_item)
   );

   cau_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_ready (fr_ready),
      .wr_item  (fr_item),
      .rd_valid (bk_valid),
      .rd_ready (bk_ready),
      .rd_item  (bk_item)
   );

   cau_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (bk_valid),
      .in_ready (bk_ready),
      .in_item  (bk_item),
      .rsp      (rsp_chan)
   );

endmodule
